@@ rtl/core/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the frame run range compressor: run
// direction codes, the result record and the push bundle between the run
// tracker and the result queue.
// ----------------------------------------------------------------------------
package frc_pkg;

   localparam int FRAME_WIDTH = 64;

   // Result queue sizing: two slots per request plus room to drain
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Number of results one request may produce
   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   // Limits of the signed frame range, as raw bits
   localparam logic [FRAME_WIDTH-1:0] FRAME_TOP    = {1'b0, {(FRAME_WIDTH-1){1'b1}}};
   localparam logic [FRAME_WIDTH-1:0] FRAME_BOTTOM = {1'b1, {(FRAME_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef struct packed {
      logic signed [FRAME_WIDTH-1:0] first;
      logic signed [FRAME_WIDTH-1:0] last;
      logic                          final_run;
   } run_type;

   typedef struct packed {
      logic [1:0] count;
      run_type    run0;
      run_type    run1;
   } push_type;

endpackage

@@ rtl/core/frame_run_range_compressor.sv @@
// ----------------------------------------------------------------------------
// frame_run_range_compressor
// Output: a closed run is registered in the result queue and shown on rsp_
// once older runs are taken. Throughput: one request per cycle while two slots
// are free; a four-slot result queue holds both runs of a request for rsp_.
// Reset: synchronous; clears the open run and empties the result queue.
// ----------------------------------------------------------------------------
module frame_run_range_compressor
   import frc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [FRAME_WIDTH-1:0] req_frame,
   input  logic                          req_end_of_list,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FRAME_WIDTH-1:0] rsp_run_first,
   output logic signed [FRAME_WIDTH-1:0] rsp_run_last,
   output logic                          rsp_final_run
);

   push_type push;
   run_type  out_run;
   logic     space;

   assign req_ready = space;

   // Track the open run
   frc_run_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_valid && space),
      .frame       (req_frame),
      .end_of_list (req_end_of_list),
      .push        (push)
   );

   // Queue finished runs for the response side
   frc_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_run   (out_run)
   );

   assign rsp_run_first = out_run.first;
   assign rsp_run_last  = out_run.last;
   assign rsp_final_run = out_run.final_run;

endmodule

@@ rtl/core/frc_run_tracker.sv @@
// ----------------------------------------------------------------------------
// frc_run_tracker
// Holds the open run and classifies each accepted frame against the previous
// one. Produces zero, one or two finished runs per request, combinationally.
// ----------------------------------------------------------------------------
module frc_run_tracker
   import frc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [FRAME_WIDTH-1:0] frame,
   input  logic                          end_of_list,
   output push_type                      push
);

   logic [FRAME_WIDTH-1:0] prev_ff, prev_in;
   logic [FRAME_WIDTH-1:0] start_ff, start_in;
   dir_type                dir_ff, dir_in;
   logic                   have_ff, have_in;

   logic [FRAME_WIDTH-1:0] frame_bits;
   dir_type                step;
   logic                   extend;
   logic                   broken;

   assign frame_bits = frame;

   // Classify the step from the previous frame; overflow at the limits is a gap
   always_comb begin
      if (prev_ff != FRAME_TOP && prev_ff + FRAME_WIDTH'(1) == frame_bits) begin
         step = DIR_UP;
      end else if (prev_ff != FRAME_BOTTOM && prev_ff - FRAME_WIDTH'(1) == frame_bits) begin
         step = DIR_DOWN;
      end else begin
         step = DIR_NONE;
      end
   end

   assign extend = (step != DIR_NONE) && (dir_ff == DIR_NONE || dir_ff == step);
   assign broken = have_ff && !extend;

   // Build the finished runs: broken run first, flushed final run second
   always_comb begin
      push.count          = PUSH_NONE;
      push.run0.first     = start_ff;
      push.run0.last      = prev_ff;
      push.run0.final_run = 1'b0;
      push.run1.first     = frame;
      push.run1.last      = frame;
      push.run1.final_run = 1'b1;
      if (accept) begin
         if (broken) begin
            push.count = end_of_list ? PUSH_TWO : PUSH_ONE;
         end else if (end_of_list) begin
            push.count          = PUSH_ONE;
            push.run0.first     = have_ff ? start_ff : frame_bits;
            push.run0.last      = frame;
            push.run0.final_run = 1'b1;
         end
      end
   end

   // Advance the open run; a flush returns to the reset state
   always_comb begin
      prev_in  = prev_ff;
      start_in = start_ff;
      dir_in   = dir_ff;
      have_in  = have_ff;
      if (accept) begin
         if (end_of_list) begin
            prev_in  = '0;
            start_in = '0;
            dir_in   = DIR_NONE;
            have_in  = 1'b0;
         end else if (!have_ff || broken) begin
            prev_in  = frame_bits;
            start_in = frame_bits;
            dir_in   = DIR_NONE;
            have_in  = 1'b1;
         end else begin
            prev_in  = frame_bits;
            dir_in   = step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         start_ff <= '0;
         dir_ff   <= DIR_NONE;
         have_ff  <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         start_ff <= start_in;
         dir_ff   <= dir_in;
         have_ff  <= have_in;
      end
   end

endmodule

@@ rtl/core/frc_result_queue.sv @@
// ----------------------------------------------------------------------------
// frc_result_queue
// Small result queue: takes up to two runs per cycle, hands out one per cycle
// if taken, from a registered slot. Ready for requests while two slots are free.
// ----------------------------------------------------------------------------
module frc_result_queue
   import frc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      space,
   output logic      out_valid,
   input  logic      out_ready,
   output run_type   out_run
);

   run_type                      slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         pop;

   assign space     = count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_run   = slots_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_WIDTH'(push.count)
                  - QUEUE_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed runs in order
   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         slots_ff[wr_ptr_ff] <= push.run0;
      end
      if (push.count == PUSH_TWO) begin
         slots_ff[wr_ptr_ff + QUEUE_PTR_WIDTH'(1)] <= push.run1;
      end
   end

endmodule

@@ verif/frc_run_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frc_run_checker
// Watches both channels of the frame run range compressor. Each accepted
// request goes through a local run tracker, and the runs it closes are
// queued. Each accepted response is compared field by field with the oldest
// queued run. Reports the failure count and the number of runs still due.
// ----------------------------------------------------------------------------
module frc_run_checker
   import frc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [FRAME_WIDTH-1:0] req_frame,
   input  logic                          req_end_of_list,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [FRAME_WIDTH-1:0] rsp_run_first,
   input  logic signed [FRAME_WIDTH-1:0] rsp_run_last,
   input  logic                          rsp_final_run,
   output int                            failures,
   output int                            pending_runs
);

   // Tracker copy of the open run
   logic [FRAME_WIDTH-1:0] run_end;
   logic [FRAME_WIDTH-1:0] run_start;
   dir_type                run_dir;
   logic                   run_open;

   run_type predicted_runs[$];
   run_type oldest_run;
   int      fail_total = 0;

   // Classify one step; a step that would wrap at the limits is a gap
   function automatic dir_type step_direction(logic [FRAME_WIDTH-1:0] from_frame,
                                              logic [FRAME_WIDTH-1:0] to_frame);
      if (from_frame != FRAME_TOP && from_frame + 64'd1 == to_frame) begin
         return DIR_UP;
      end
      if (from_frame != FRAME_BOTTOM && from_frame - 64'd1 == to_frame) begin
         return DIR_DOWN;
      end
      return DIR_NONE;
   endfunction

   task automatic close_run(logic [FRAME_WIDTH-1:0] first_frame,
                            logic [FRAME_WIDTH-1:0] last_frame, logic is_final);
      run_type closed;
      closed.first     = first_frame;
      closed.last      = last_frame;
      closed.final_run = is_final;
      predicted_runs.push_back(closed);
   endtask

   task automatic clear_run();
      run_start = '0;
      run_end   = '0;
      run_dir   = DIR_NONE;
      run_open  = 1'b0;
   endtask

   // Advance the tracker by one frame and queue the runs it closes
   task automatic track_frame(logic [FRAME_WIDTH-1:0] frame, logic end_of_list);
      dir_type step;
      step = DIR_NONE;
      if (!run_open) begin
         run_start = frame;
         run_end   = frame;
         run_dir   = DIR_NONE;
         run_open  = 1'b1;
      end else begin
         step = step_direction(run_end, frame);
         if (step != DIR_NONE && (run_dir == DIR_NONE || run_dir == step)) begin
            run_dir = step;
            run_end = frame;
         end else begin
            // Gap, repeat or turn: emit the run so far, restart at this frame
            close_run(run_start, run_end, 1'b0);
            run_start = frame;
            run_end   = frame;
            run_dir   = DIR_NONE;
         end
      end
      if (end_of_list) begin
         close_run(run_start, run_end, 1'b1);
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         predicted_runs.delete();
         clear_run();
      end else begin
         if (req_valid && req_ready) begin
            track_frame(req_frame, req_end_of_list);
         end
         // Compare each response with the oldest predicted run
         if (rsp_valid && rsp_ready) begin
            if (predicted_runs.size() == 0) begin
               $display("%0t: unexpected run first=%0d last=%0d final=%0b",
                        $time, rsp_run_first, rsp_run_last, rsp_final_run);
               fail_total++;
            end else begin
               oldest_run = predicted_runs.pop_front();
               if (rsp_run_first !== oldest_run.first) begin
                  $display("%0t: run_first expected %0d, got %0d",
                           $time, oldest_run.first, rsp_run_first);
                  fail_total++;
               end
               if (rsp_run_last !== oldest_run.last) begin
                  $display("%0t: run_last expected %0d, got %0d",
                           $time, oldest_run.last, rsp_run_last);
                  fail_total++;
               end
               if (rsp_final_run !== oldest_run.final_run) begin
                  $display("%0t: final_run expected %0b, got %0b",
                           $time, oldest_run.final_run, rsp_final_run);
                  fail_total++;
               end
            end
         end
      end
      failures     <= fail_total;
      pending_runs <= predicted_runs.size();
   end

endmodule

@@ verif/frame_run_range_compressor_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_run_range_compressor_test
// Drives frame requests into the compressor: a directed part covering the
// range limits, repeats, turns and flushes, then random sequences built
// mostly from runs with random jumps, turns and end markers. The sender
// works in bursts, the receiver stalls in patterns and once for a long
// stretch. A checker beside the block predicts and compares every run.
// ----------------------------------------------------------------------------
module frame_run_range_compressor_test
   import frc_pkg::*;
();

   localparam int RANDOM_FRAMES = 750;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 300;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [FRAME_WIDTH-1:0] req_frame;
   logic                          req_end_of_list;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [FRAME_WIDTH-1:0] rsp_run_first;
   logic signed [FRAME_WIDTH-1:0] rsp_run_last;
   logic                          rsp_final_run;
   int                            failures;
   int                            pending_runs;

   logic                   hold_off_active = 1'b0;
   logic                   hold_off_done   = 1'b0;
   int                     burst_left      = 0;
   int                     ready_cycles    = 0;
   int                     frames_left;
   int                     drain_wait;
   int                     roll;
   int                     stretch;
   int                     ready_mode;
   logic [FRAME_WIDTH-1:0] cursor;
   logic                   heading_up;
   logic                   flag_end;

   frame_run_range_compressor u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame       (req_frame),
      .req_end_of_list (req_end_of_list),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_first   (rsp_run_first),
      .rsp_run_last    (rsp_run_last),
      .rsp_final_run   (rsp_final_run)
   );

   frc_run_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame       (req_frame),
      .req_end_of_list (req_end_of_list),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_first   (rsp_run_first),
      .rsp_run_last    (rsp_run_last),
      .rsp_final_run   (rsp_final_run),
      .failures        (failures),
      .pending_runs    (pending_runs)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run in case the block hangs
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   // Offer one request and hold it until accepted, then idle between bursts
   task automatic send_frame(logic [FRAME_WIDTH-1:0] frame, logic end_of_list);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_frame       <= frame;
      req_end_of_list <= end_of_list;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0 && !hold_off_active) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Pick a jump target: anywhere, near either limit, or near zero
   function automatic logic [FRAME_WIDTH-1:0] random_frame();
      logic [FRAME_WIDTH-1:0] small_value;
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return FRAME_TOP - 64'($urandom_range(0, 3));
         2: return FRAME_BOTTOM + 64'($urandom_range(0, 3));
         default: begin
            small_value = 64'($urandom_range(0, 64));
            return small_value - 64'd32;
         end
      endcase
   endfunction

   // Stimulus
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_frame       = '0;
      req_end_of_list = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone frames flagged last, at both limits
      send_frame(FRAME_TOP, 1'b1);
      send_frame(FRAME_BOTTOM, 1'b1);
      // Climb to the top, then a step that would wrap upward
      send_frame(FRAME_TOP - 2, 1'b0);
      send_frame(FRAME_TOP - 1, 1'b0);
      send_frame(FRAME_TOP, 1'b0);
      send_frame(FRAME_BOTTOM, 1'b0);
      // Descend to the bottom, then a step that would wrap downward
      send_frame(FRAME_BOTTOM + 2, 1'b0);
      send_frame(FRAME_BOTTOM + 1, 1'b0);
      send_frame(FRAME_BOTTOM, 1'b0);
      send_frame(FRAME_TOP, 1'b0);
      send_frame(FRAME_TOP - 1, 1'b1);
      // Repeated frame
      send_frame(64'd5, 1'b0);
      send_frame(64'd5, 1'b0);
      send_frame(64'd6, 1'b1);
      // Turn at the top of an ascending run
      send_frame(64'd10, 1'b0);
      send_frame(64'd11, 1'b0);
      send_frame(64'd12, 1'b0);
      send_frame(64'd11, 1'b0);
      send_frame(64'd10, 1'b0);
      send_frame(64'd9, 1'b1);
      // Descend through zero
      send_frame(64'd1, 1'b0);
      send_frame(64'd0, 1'b0);
      send_frame(-64'sd1, 1'b1);
      // Gap on the last frame closes two runs at once
      send_frame(64'd100, 1'b0);
      send_frame(64'd200, 1'b1);

      // Random sequences: mostly runs, with jumps, repeats and turns
      cursor      = random_frame();
      heading_up  = 1'($urandom_range(0, 1));
      frames_left = RANDOM_FRAMES;
      while (frames_left > 0) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 8) begin
            cursor     = random_frame();
            heading_up = 1'($urandom_range(0, 1));
         end else if (roll < 16) begin
            cursor = cursor;
         end else begin
            if (roll < 24) begin
               heading_up = ~heading_up;
            end
            cursor = heading_up ? cursor + 64'd1 : cursor - 64'd1;
         end
         flag_end = (frames_left == 1) || ($urandom_range(0, 11) == 0);
         send_frame(cursor, flag_end);
         frames_left--;
      end

      // Drain the remaining runs, then let the pipeline settle
      @(negedge clock);
      req_valid <= 1'b0;
      drain_wait = 0;
      while (pending_runs != 0 && drain_wait < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (8) @(negedge clock);
      if (failures == 0 && pending_runs == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver: stretches of differing stall patterns, one long hold-off
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         if (!hold_off_done && ready_cycles > 400) begin
            hold_off_active = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_active = 1'b0;
            hold_off_done   = 1'b1;
         end
         stretch    = int'($urandom_range(8, 60));
         ready_mode = int'($urandom_range(0, 3));
         repeat (stretch) begin
            @(negedge clock);
            case (ready_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
            ready_cycles++;
         end
      end
   end

endmodule

@@ filelist.f @@
rtl/core/frc_pkg.sv
rtl/core/frc_run_tracker.sv
rtl/core/frc_result_queue.sv
rtl/core/frame_run_range_compressor.sv
verif/frc_run_checker.sv
verif/frame_run_range_compressor_test.sv
